FILE: src/grlt_pkg.sv
// shared constants, codes and types of the group rate limiter table
`default_nettype none

package grlt_pkg;

    localparam int GROUPS_DEF = 16;

    localparam int OP_W     = 3;
    localparam int GID_W    = 10;
    localparam int AMT_W    = 20;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int ST_W     = 2;
    localparam int KB_SHIFT = 10;
    localparam int CHUNK_W  = 32;

    localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE     = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_RATE = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD      = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // one direction of one group as kept in the table memory
    typedef struct packed {
        logic [AMT_W-1:0]  limit;
        logic [CNT_W-1:0]  bytes;
        logic [TIME_W-1:0] window;
    } t_entry;

endpackage

`default_nettype wire

FILE: src/grlt_cmd_if.sv
// command channel of the group rate limiter table
`default_nettype none

interface grlt_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [grlt_pkg::OP_W-1:0]    opcode;
    logic                         direction;
    logic [grlt_pkg::GID_W-1:0]   group_id;
    logic [grlt_pkg::AMT_W-1:0]   amount;
    logic [grlt_pkg::TIME_W-1:0]  now_seconds;

    modport source (
        output valid, opcode, direction, group_id, amount, now_seconds,
        input  ready
    );
    modport sink (
        input  valid, opcode, direction, group_id, amount, now_seconds,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/grlt_res_if.sv
// result channel of the group rate limiter table
`default_nettype none

interface grlt_res_if;
    logic                        valid;
    logic                        ready;
    logic [grlt_pkg::ST_W-1:0]   status;
    logic                        allowed;
    logic [grlt_pkg::GID_W-1:0]  new_group;

    modport source (
        output valid, status, allowed, new_group,
        input  ready
    );
    modport sink (
        input  valid, status, allowed, new_group,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/grlt_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module grlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/group_rate_limiter_table.sv
// group rate limiter table: per-group fixed-window byte limits, group 0 global
//
// channels: i_cmd carries one command beat (opcode, direction, group_id,
// amount, now_seconds); o_res returns exactly one result beat per command
// (status, allowed, new_group), in command order. both use valid/ready.
// commands: one at a time, accept + read-modify-write of the table memory,
// whose read is registered; ready stays low until the result is taken into
// the output register. alloc scans the in-use bits 32 per cycle.
// the result sits in an output register, so a command is accepted while the
// previous result is still waiting; a stalled receiver holds the next command
// in its execute cycle until the output register frees up.
// reset: synchronous, active low. the table memory is then swept to zero,
// all 2 * 2**clog2(GROUPS) entries (32 for 16 groups); ready stays low meanwhile.
// group 0 (the global group) lives in flip-flops, the other groups in memory.
`default_nettype none

module group_rate_limiter_table #(
    parameter int GROUPS = grlt_pkg::GROUPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    grlt_cmd_if.sink   i_cmd,
    grlt_res_if.source o_res
);

    localparam int GW     = $clog2(GROUPS);
    localparam int AW     = GW + 1;
    localparam int DEPTH  = 2 ** AW;
    localparam int CW_BIT = grlt_pkg::CHUNK_W;
    localparam int NCHUNK = (GROUPS + CW_BIT - 1) / CW_BIT;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PW     = $clog2(CW_BIT);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state r_state;
    logic [AW-1:0] r_clr_addr;
    logic [CW-1:0] r_chunk;
    logic [GROUPS-1:0] r_in_use;

    // global group, per direction
    logic [1:0][grlt_pkg::AMT_W-1:0]  r_lim0;
    logic [1:0][grlt_pkg::CNT_W-1:0]  r_cnt0;
    logic [1:0][grlt_pkg::TIME_W-1:0] r_win0;

    // latched command
    logic [grlt_pkg::OP_W-1:0]   r_op;
    logic                        r_dir;
    logic [grlt_pkg::GID_W-1:0]  r_gid;
    logic [grlt_pkg::AMT_W-1:0]  r_amt;
    logic [grlt_pkg::TIME_W-1:0] r_now;

    logic                        r_out_valid;
    logic [grlt_pkg::ST_W-1:0]   r_out_status;
    logic                        r_out_allowed;
    logic [grlt_pkg::GID_W-1:0]  r_out_newg;

    logic accept;
    logic out_free;
    logic gid_ok;
    logic gid_zero;
    grlt_pkg::t_entry ram_rdata;
    grlt_pkg::t_entry cur;
    grlt_pkg::t_entry n_entry;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    grlt_pkg::t_entry     ram_wdata;

    logic [NCHUNK*CW_BIT-1:0] use_pad;
    logic [CW_BIT-1:0]        chunk_bits;
    logic [PW-1:0]            free_pos;
    logic                     free_found;
    logic                     last_chunk;
    logic                     done;
    logic                     emit;

    logic [grlt_pkg::ST_W-1:0]  n_status;
    logic                       n_allowed;
    logic [grlt_pkg::GID_W-1:0] n_newg;
    logic                       n_wr_ram;
    logic                       n_wr_g;
    logic                       n_gadd;
    logic                       n_free;
    logic                       n_claim;
    logic [GW-1:0]              n_claim_idx;
    logic [grlt_pkg::CNT_W-1:0] n_cnt0_sum;
    logic [grlt_pkg::CNT_W:0]   sum_g;
    logic [grlt_pkg::CNT_W:0]   sum_e;
    logic                       win_new;
    logic [grlt_pkg::CNT_W-1:0] rate_bytes;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.allowed   = r_out_allowed;
    assign o_res.new_group = r_out_newg;

    grlt_ram #(
        .WIDTH ($bits(grlt_pkg::t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr ({i_cmd.direction, i_cmd.group_id[GW-1:0]}),
        .o_rdata (ram_rdata)
    );

    assign gid_ok   = 32'(r_gid) < 32'(GROUPS);
    assign gid_zero = (r_gid == '0);
    assign cur      = gid_zero ? grlt_pkg::t_entry'({r_lim0[r_dir], r_cnt0[r_dir], r_win0[r_dir]})
                               : ram_rdata;

    // first free entry in the current 32-entry slice; entry 0 and padding count as used
    always_comb begin
        use_pad = '1;
        use_pad[GROUPS-1:0] = r_in_use;
        use_pad[0] = 1'b1;
        chunk_bits = use_pad[32'(r_chunk) * CW_BIT +: CW_BIT];
        free_pos   = '0;
        free_found = 1'b0;
        for (int i = CW_BIT - 1; i >= 0; i--) begin
            if (!chunk_bits[i]) begin
                free_pos   = PW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign last_chunk = (32'(r_chunk) == NCHUNK - 1);
    assign done = (r_op != grlt_pkg::OP_ALLOC) || free_found || last_chunk;
    assign emit = (r_state == S_EXEC) && done && out_free;

    assign sum_g      = {1'b0, r_cnt0[r_dir]} + (grlt_pkg::CNT_W + 1)'(r_amt);
    assign n_cnt0_sum = sum_g[grlt_pkg::CNT_W] ? '1 : sum_g[grlt_pkg::CNT_W-1:0];
    assign sum_e      = {1'b0, cur.bytes} + (grlt_pkg::CNT_W + 1)'(r_amt);
    assign win_new    = cur.window < r_now;
    assign rate_bytes = grlt_pkg::CNT_W'({cur.limit, {grlt_pkg::KB_SHIFT{1'b0}}});

    always_comb begin
        n_status    = grlt_pkg::ST_OK;
        n_allowed   = 1'b0;
        n_newg      = '0;
        n_entry     = cur;
        n_wr_ram    = 1'b0;
        n_wr_g      = 1'b0;
        n_gadd      = 1'b0;
        n_free      = 1'b0;
        n_claim     = 1'b0;
        n_claim_idx = GW'({r_chunk, free_pos});
        unique case (r_op)
            grlt_pkg::OP_ALLOC: begin
                if (free_found) begin
                    n_claim = 1'b1;
                    n_newg  = grlt_pkg::GID_W'({r_chunk, free_pos});
                end else begin
                    n_status = grlt_pkg::ST_FULL;
                end
            end
            grlt_pkg::OP_FREE: begin
                if (gid_ok) n_free = 1'b1;
                else        n_status = grlt_pkg::ST_RANGE;
            end
            grlt_pkg::OP_SET_RATE: begin
                n_entry.limit = r_amt;
                if (!gid_ok)       n_status = grlt_pkg::ST_RANGE;
                else if (gid_zero) n_wr_g   = 1'b1;
                else               n_wr_ram = 1'b1;
            end
            grlt_pkg::OP_ADD: begin
                n_entry.bytes = sum_e[grlt_pkg::CNT_W] ? '1 : sum_e[grlt_pkg::CNT_W-1:0];
                if (!gid_ok)        n_status = grlt_pkg::ST_RANGE;
                else if (!gid_zero) n_wr_ram = 1'b1;
                n_gadd = (r_lim0[r_dir] != '0);
            end
            grlt_pkg::OP_CHECK: begin
                n_allowed = 1'b1;
                if (!gid_ok) begin
                    n_status = grlt_pkg::ST_RANGE;
                end else if (cur.limit != '0) begin
                    // a later second opens a fresh window
                    if (win_new) begin
                        n_entry.window = r_now;
                        n_entry.bytes  = '0;
                    end
                    n_allowed = !(n_entry.bytes > rate_bytes);
                    n_wr_g    = gid_zero;
                    n_wr_ram  = !gid_zero;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = emit && n_wr_ram;
            ram_waddr = {r_dir, r_gid[GW-1:0]};
            ram_wdata = n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_chunk     <= '0;
            r_in_use    <= '0;
            r_lim0      <= '0;
            r_cnt0      <= '0;
            r_win0      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit)             r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_cmd.opcode;
                        r_dir   <= i_cmd.direction;
                        r_gid   <= i_cmd.group_id;
                        r_amt   <= i_cmd.amount;
                        r_now   <= i_cmd.now_seconds;
                        r_chunk <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!done) begin
                        r_chunk <= r_chunk + 1'b1;
                    end else if (emit) begin
                        r_out_status  <= n_status;
                        r_out_allowed <= n_allowed;
                        r_out_newg    <= n_newg;
                        if (n_claim) r_in_use[n_claim_idx] <= 1'b1;
                        if (n_free)  r_in_use[r_gid[GW-1:0]] <= 1'b0;
                        if (n_wr_g) begin
                            r_lim0[r_dir] <= n_entry.limit;
                            r_cnt0[r_dir] <= n_entry.bytes;
                            r_win0[r_dir] <= n_entry.window;
                        end
                        if (n_gadd) r_cnt0[r_dir] <= n_cnt0_sum;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/grlt_checker.sv
// port-level assertions for the group rate limiter table, bound to the top level
`default_nettype none

module grlt_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_cmd_valid,
    input wire logic                       i_cmd_ready,
    input wire logic                       i_res_valid,
    input wire logic                       i_res_ready,
    input wire logic [grlt_pkg::ST_W-1:0]  i_res_status,
    input wire logic                       i_res_allowed,
    input wire logic [grlt_pkg::GID_W-1:0] i_res_new_group
);

    // a stalled result beat stays put
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status)
            && $stable(i_res_allowed) && $stable(i_res_new_group))
        else $error("result beat changed while stalled");

    // one command at a time: ready drops right after an accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command accepted while previous one executes");

    // a claimed index only comes with an ok status and no check verdict
    a_newg_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_new_group != '0 |->
            i_res_status == grlt_pkg::ST_OK && !i_res_allowed)
        else $error("new_group set on a non-alloc or failed result");

    // table full never reports an index
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status == grlt_pkg::ST_FULL |->
            i_res_new_group == '0 && !i_res_allowed)
        else $error("table full result carries an index or verdict");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind group_rate_limiter_table grlt_checker u_grlt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_status    (o_res.status),
    .i_res_allowed   (o_res.allowed),
    .i_res_new_group (o_res.new_group)
);

`default_nettype wire
